>>> rtl/gauge_attack_release_smoother_assert.svh
// Assertion macros shared by the smoother RTL files.
`ifndef GAUGE_ATTACK_RELEASE_SMOOTHER_ASSERT_SVH
`define GAUGE_ATTACK_RELEASE_SMOOTHER_ASSERT_SVH
`ifndef SYNTHESIS
`define GARS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GARS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GARS_ASSERT(label, prop, msg)
`define GARS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

>>> rtl/gars_pkg.sv
// Shared types and constants of the gauge smoother.
package gars_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MID    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_HIGH   = 3'd5;

    localparam logic [7:0]  RST_FULL_SCALE   = 8'd100;
    localparam logic [7:0]  RST_ATTACK_GAIN  = 8'd77;
    localparam logic [7:0]  RST_RELEASE_GAIN = 8'd13;
    localparam logic [23:0] RST_COLOR_LOW    = 24'h00C8FF;
    localparam logic [23:0] RST_COLOR_MID    = 24'hFFB000;
    localparam logic [23:0] RST_COLOR_HIGH   = 24'hFF2020;

    localparam int RATIO_W = 17;
    localparam logic [RATIO_W-1:0] RATIO_ONE  = 17'h10000;
    localparam logic [RATIO_W-1:0] RATIO_HALF = 17'h08000;

    typedef struct packed {
        logic       load;
        logic [7:0] level;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  full_scale;
        logic [7:0]  attack_gain;
        logic [7:0]  release_gain;
        logic [23:0] color_low;
        logic [23:0] color_mid;
        logic [23:0] color_high;
    } cfg_t;

    typedef struct packed {
        logic [7:0] shown_level;
        logic [9:0] fill_amount;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       settled;
    } result_t;

endpackage

>>> rtl/gars_if.sv
// Valid/ready channel interfaces for commands and results.
interface gars_cmd_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] level;

    modport source (output valid, output kind, output level, input ready);
    modport sink (input valid, input kind, input level, output ready);
endinterface

interface gars_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] shown_level;
    logic [9:0] fill_amount;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       settled;

    modport source (output valid, output shown_level, output fill_amount, output red,
                    output green, output blue, output settled, input ready);
    modport sink (input valid, input shown_level, input fill_amount, input red,
                  input green, input blue, input settled, output ready);
endinterface

>>> rtl/gars_front.sv
// Command front end: accept, classify and queue items for the step engine.
`include "gauge_attack_release_smoother_assert.svh"

module gars_front (
    input  logic           clk,
    input  logic           rst_n,
    gars_cmd_if.sink       cmd,
    output gars_pkg::cmd_t q_cmd,
    output logic           q_valid,
    input  logic           q_ready
);
    import gars_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;
    cmd_t             incoming;

    assign cmd.ready = (count_reg != CNT_W'(DEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_valid && q_ready;
    assign q_cmd     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        incoming.load  = ~cmd.kind;
        incoming.level = cmd.level;
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

    `GARS_ASSERT(a_count_range, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `GARS_ASSERT(a_count_up, push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1),
        "queue count missed a push")
    `GARS_ASSERT(a_count_down, pop && !push |=> count_reg == $past(count_reg) - CNT_W'(1),
        "queue count missed a pop")

endmodule

>>> rtl/gars_back.sv
// Step engine: level smoothing, iterative ratio divide, fill and color ramp.
`include "gauge_attack_release_smoother_assert.svh"

module gars_back #(
    parameter int FILL_SCALE = 1000,
    parameter int FRAC_BITS  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  gars_pkg::cfg_t cfg,
    input  gars_pkg::cmd_t q_cmd,
    input  logic           q_valid,
    output logic           q_ready,
    gars_result_if.source  result
);
    import gars_pkg::*;

    localparam int W      = 8 + FRAC_BITS;
    localparam int FILL_W = $clog2(FILL_SCALE + 1);
    localparam int PROD_W = (RATIO_W + FILL_W + 1 > 26) ? RATIO_W + FILL_W + 1 : 26;
    localparam int QUO_W  = 16;
    localparam int CNT_W  = $clog2(QUO_W);
    localparam logic [W-1:0] HALF_Q = {{(W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STEP  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [W-1:0]        shown_q_reg, shown_q_next;
    logic [7:0]          goal_reg, goal_next;
    logic [W-1:0]        step_reg, step_next;
    logic                snap_reg, snap_next;
    logic                up_reg, up_next;
    logic                settled_reg, settled_next;
    logic [W:0]          rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RATIO_W-1:0]  ratio_reg, ratio_next;
    logic [PROD_W-1:0]   fill_prod_reg, fill_prod_next;
    logic [7:0]          base_reg [3];
    logic [7:0]          base_next [3];
    logic [7:0]          mag_reg [3];
    logic [7:0]          mag_next [3];
    logic                dn_reg [3];
    logic                dn_next [3];
    result_t             result_reg, result_next;
    logic                out_valid_reg, out_valid_next;

    logic [W-1:0]        goal_q;
    logic [W-1:0]        diff;
    logic [7:0]          gain;
    logic [W+7:0]        step_prod;
    logic [W-1:0]        step_raw;
    logic [W-1:0]        shown_upd;
    logic [W-1:0]        dvs;
    logic [W:0]          rem_sh;
    logic                rem_ge;
    logic [QUO_W-1:0]    quo_shift;
    logic                low_half;
    logic [RATIO_W-1:0]  t_base;
    logic [RATIO_W-1:0]  ramp_t;
    logic [23:0]         col_a;
    logic [23:0]         col_b;
    logic [7:0]          ca;
    logic [7:0]          cb;
    logic [7:0]          dmag;
    logic [24:0]         ramp_prod;
    logic [PROD_W-1:0]   fill_sum;
    logic [W:0]          shown_rnd;
    logic                out_free;

    assign goal_q    = {goal_reg, {FRAC_BITS{1'b0}}};
    assign dvs       = {cfg.full_scale, {FRAC_BITS{1'b0}}};
    assign up_next   = (shown_q_reg <= goal_q);
    assign diff      = up_next ? goal_q - shown_q_reg : shown_q_reg - goal_q;
    assign gain      = up_next ? cfg.attack_gain : cfg.release_gain;
    assign step_prod = (W + 8)'(diff) * (W + 8)'(gain);
    assign step_raw  = step_prod[W+7:8];
    assign shown_upd = snap_reg ? goal_q : (up_reg ? shown_q_reg + step_reg
                                                   : shown_q_reg - step_reg);
    assign rem_sh    = {rem_reg[W-1:0], 1'b0};
    assign rem_ge    = (rem_sh >= {1'b0, dvs});
    assign quo_shift = {quo_reg[QUO_W-2:0], rem_ge};
    assign low_half  = (ratio_reg < RATIO_HALF);
    assign t_base    = low_half ? ratio_reg : ratio_reg - RATIO_HALF;
    assign ramp_t    = {t_base[RATIO_W-2:0], 1'b0};
    assign col_a     = low_half ? cfg.color_low : cfg.color_mid;
    assign col_b     = low_half ? cfg.color_mid : cfg.color_high;
    assign fill_sum  = fill_prod_reg + PROD_W'(RATIO_HALF);
    assign shown_rnd = {1'b0, shown_q_reg} + (W + 1)'(HALF_Q);
    assign out_free  = !out_valid_reg || result.ready;
    assign q_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        shown_q_next   = shown_q_reg;
        goal_next      = goal_reg;
        step_next      = step_reg;
        snap_next      = snap_reg;
        settled_next   = settled_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        ratio_next     = ratio_reg;
        fill_prod_next = fill_prod_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !result.ready;
        ca             = '0;
        cb             = '0;
        dmag           = '0;
        ramp_prod      = '0;
        for (int c = 0; c < 3; c++)
        begin
            base_next[c] = base_reg[c];
            mag_next[c]  = mag_reg[c];
            dn_next[c]   = dn_reg[c];
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.load)
                    begin
                        goal_next = q_cmd.level;
                    end
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                snap_next  = (diff < HALF_Q);
                step_next  = (step_raw == '0) ? {{(W-1){1'b0}}, 1'b1} : step_raw;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                shown_q_next = shown_upd;
                settled_next = (shown_upd == goal_q);
                rem_next     = {1'b0, shown_upd};
                quo_next     = '0;
                cnt_next     = '0;
                if (cfg.full_scale == '0 || shown_upd >= dvs)
                begin
                    ratio_next = RATIO_ONE;
                    state_next = S_SCALE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = rem_ge ? rem_sh - {1'b0, dvs} : rem_sh;
                quo_next = quo_shift;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    ratio_next = {1'b0, quo_shift};
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                fill_prod_next = PROD_W'(ratio_reg) * PROD_W'(FILL_SCALE);
                for (int c = 0; c < 3; c++)
                begin
                    ca           = col_a[8*(2-c) +: 8];
                    cb           = col_b[8*(2-c) +: 8];
                    dmag         = (cb >= ca) ? cb - ca : ca - cb;
                    ramp_prod    = 25'(dmag) * 25'(ramp_t);
                    base_next[c] = ca;
                    dn_next[c]   = (cb < ca);
                    mag_next[c]  = ramp_prod[23:16];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    result_next.shown_level = shown_rnd[FRAC_BITS+7:FRAC_BITS];
                    result_next.fill_amount = fill_sum[25:16];
                    result_next.red   = dn_reg[0] ? base_reg[0] - mag_reg[0]
                                                  : base_reg[0] + mag_reg[0];
                    result_next.green = dn_reg[1] ? base_reg[1] - mag_reg[1]
                                                  : base_reg[1] + mag_reg[1];
                    result_next.blue  = dn_reg[2] ? base_reg[2] - mag_reg[2]
                                                  : base_reg[2] + mag_reg[2];
                    result_next.settled = settled_reg;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            shown_q_reg   <= '0;
            goal_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shown_q_reg   <= shown_q_next;
            goal_reg      <= goal_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        snap_reg      <= snap_next;
        up_reg        <= up_next;
        settled_reg   <= settled_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        ratio_reg     <= ratio_next;
        fill_prod_reg <= fill_prod_next;
        result_reg    <= result_next;
        for (int c = 0; c < 3; c++)
        begin
            base_reg[c] <= base_next[c];
            mag_reg[c]  <= mag_next[c];
            dn_reg[c]   <= dn_next[c];
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.shown_level = result_reg.shown_level;
    assign result.fill_amount = result_reg.fill_amount;
    assign result.red         = result_reg.red;
    assign result.green       = result_reg.green;
    assign result.blue        = result_reg.blue;
    assign result.settled     = result_reg.settled;

    `GARS_ASSERT(a_step_nonzero, state_reg == S_APPLY && !snap_reg |-> step_reg != '0,
        "non-snap step of zero")
    `GARS_ASSERT(a_ratio_range, state_reg == S_SCALE |-> ratio_reg <= RATIO_ONE,
        "ratio above full scale")
    `GARS_ASSERT(a_settled_goal, state_reg == S_DONE && settled_reg |-> shown_q_reg == goal_q,
        "settled flag without level at goal")

endmodule

>>> rtl/gauge_attack_release_smoother.sv
// Top level of the attack/release gauge smoother with color ramp.
// Each command (new target level or timer tick) advances the displayed level
// one attack/release step and returns one result: rounded level, fill value,
// RGB fill color and a settled flag. An item goes from acceptance through a
// load state, the step multiply and update, the one-bit-per-cycle restoring
// divider that forms level/full_scale, the fill and color multipliers and a
// result register written once the output is free. At or above full scale (or
// with full scale zero) the divider is skipped. A two-entry queue accepts
// commands while the engine works; the output register holds a result until
// it is taken. The user must write the configuration registers through
// wr_en/wr_index/wr_data only while the block is idle, which is not enforced.
module gauge_attack_release_smoother #(
    parameter int FILL_SCALE = 1000,
    parameter int FRAC_BITS  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    gars_cmd_if.sink                      cmd,
    gars_result_if.source                 result,
    input  logic                          wr_en,
    input  logic [gars_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [gars_pkg::CFG_DATA_W-1:0] wr_data
);
    import gars_pkg::*;

    cfg_t cfg_reg;
    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_scale   <= RST_FULL_SCALE;
            cfg_reg.attack_gain  <= RST_ATTACK_GAIN;
            cfg_reg.release_gain <= RST_RELEASE_GAIN;
            cfg_reg.color_low    <= RST_COLOR_LOW;
            cfg_reg.color_mid    <= RST_COLOR_MID;
            cfg_reg.color_high   <= RST_COLOR_HIGH;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_FULL_SCALE:   cfg_reg.full_scale   <= wr_data[7:0];
                REG_ATTACK_GAIN:  cfg_reg.attack_gain  <= wr_data[7:0];
                REG_RELEASE_GAIN: cfg_reg.release_gain <= wr_data[7:0];
                REG_COLOR_LOW:    cfg_reg.color_low    <= wr_data;
                REG_COLOR_MID:    cfg_reg.color_mid    <= wr_data;
                REG_COLOR_HIGH:   cfg_reg.color_high   <= wr_data;
                default:
                begin
                end
            endcase
        end
    end

    gars_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    gars_back #(
        .FILL_SCALE (FILL_SCALE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_cmd   (q_cmd),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .result  (result)
    );

endmodule
